// ===== hw/rtl/rvx_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rvx_pkg
// Shared kinds, state types and command/status structs of the RV64IM
// integer execute core.
// ----------------------------------------------------------------------------
package rvx_pkg;

   localparam int XLEN = 64;

   typedef logic [5:0] kind_type;

   localparam kind_type K_LUI    = 6'd0;
   localparam kind_type K_AUIPC  = 6'd1;
   localparam kind_type K_JAL    = 6'd2;
   localparam kind_type K_JALR   = 6'd3;
   localparam kind_type K_BEQ    = 6'd4;
   localparam kind_type K_BNE    = 6'd5;
   localparam kind_type K_BLT    = 6'd6;
   localparam kind_type K_BGE    = 6'd7;
   localparam kind_type K_BLTU   = 6'd8;
   localparam kind_type K_BGEU   = 6'd9;
   localparam kind_type K_ADDI   = 6'd10;
   localparam kind_type K_XORI   = 6'd11;
   localparam kind_type K_ORI    = 6'd12;
   localparam kind_type K_ANDI   = 6'd13;
   localparam kind_type K_SLLI   = 6'd14;
   localparam kind_type K_SRLI   = 6'd15;
   localparam kind_type K_SRAI   = 6'd16;
   localparam kind_type K_SLTI   = 6'd17;
   localparam kind_type K_SLTIU  = 6'd18;
   localparam kind_type K_ADDIW  = 6'd19;
   localparam kind_type K_SLLIW  = 6'd20;
   localparam kind_type K_SRLIW  = 6'd21;
   localparam kind_type K_SRAIW  = 6'd22;
   localparam kind_type K_ADD    = 6'd23;
   localparam kind_type K_SUB    = 6'd24;
   localparam kind_type K_XOR    = 6'd25;
   localparam kind_type K_OR     = 6'd26;
   localparam kind_type K_AND    = 6'd27;
   localparam kind_type K_SLT    = 6'd28;
   localparam kind_type K_SLTU   = 6'd29;
   localparam kind_type K_SLL    = 6'd30;
   localparam kind_type K_SRL    = 6'd31;
   localparam kind_type K_SRA    = 6'd32;
   localparam kind_type K_ADDW   = 6'd33;
   localparam kind_type K_SUBW   = 6'd34;
   localparam kind_type K_SLLW   = 6'd35;
   localparam kind_type K_SRLW   = 6'd36;
   localparam kind_type K_SRAW   = 6'd37;
   localparam kind_type K_LB     = 6'd38;
   localparam kind_type K_LH     = 6'd39;
   localparam kind_type K_LW     = 6'd40;
   localparam kind_type K_LBU    = 6'd41;
   localparam kind_type K_LHU    = 6'd42;
   localparam kind_type K_LWU    = 6'd43;
   localparam kind_type K_LD     = 6'd44;
   localparam kind_type K_SB     = 6'd45;
   localparam kind_type K_SH     = 6'd46;
   localparam kind_type K_SW     = 6'd47;
   localparam kind_type K_SD     = 6'd48;
   localparam kind_type K_ECALL  = 6'd49;
   localparam kind_type K_EBREAK = 6'd50;
   localparam kind_type K_MUL    = 6'd51;
   localparam kind_type K_MULW   = 6'd52;
   localparam kind_type K_DIV    = 6'd53;
   localparam kind_type K_DIVW   = 6'd54;
   localparam kind_type K_DIVU   = 6'd55;
   localparam kind_type K_DIVUW  = 6'd56;
   localparam kind_type K_REM    = 6'd57;
   localparam kind_type K_REMW   = 6'd58;
   localparam kind_type K_REMU   = 6'd59;
   localparam kind_type K_REMUW  = 6'd60;

   localparam logic [1:0] MEM_NONE  = 2'd0;
   localparam logic [1:0] MEM_LOAD  = 2'd1;
   localparam logic [1:0] MEM_STORE = 2'd2;

   localparam logic [1:0] TRAP_NONE   = 2'd0;
   localparam logic [1:0] TRAP_ECALL  = 2'd1;
   localparam logic [1:0] TRAP_EBREAK = 2'd2;
   localparam logic [1:0] TRAP_UNSUP  = 2'd3;

   typedef enum logic [1:0] {
      CTL_IDLE,
      CTL_ALU,
      CTL_MD
   } ctl_state_type;

   typedef enum logic [2:0] {
      MD_IDLE,
      MD_MUL,
      MD_DIV,
      MD_FIX,
      MD_DONE
   } md_state_type;

   typedef struct packed {
      logic is_mul;
      logic word;
      logic sgn;
      logic rem;
   } md_op_type;

   typedef struct packed {
      logic accept;
      logic start_md;
      logic load_alu;
      logic load_md;
   } cmd_type;

   typedef struct packed {
      logic is_md;
      logic md_done;
   } status_type;

   function automatic logic [63:0] sx32(input logic [63:0] x);
      return {{32{x[31]}}, x[31:0]};
   endfunction

endpackage

// ===== hw/rtl/rvx_muldiv.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rvx_muldiv
// Iterative multiply (32x32 partial products on one multiplier) and radix-2
// restoring divide (64 iterations plus setup and sign fix).
// ----------------------------------------------------------------------------
module rvx_muldiv (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  rvx_pkg::md_op_type op,
   input  logic [63:0]       src_a,
   input  logic [63:0]       src_b,
   output logic              done,
   output logic [63:0]       result
);
   import rvx_pkg::*;

   md_state_type state_ff, state_in;
   md_op_type    op_ff, op_in;
   logic [63:0]  opa_ff, opa_in, opb_ff, opb_in;
   logic [63:0]  rem_ff, rem_in, quo_ff, quo_in;
   logic [63:0]  acc_ff, acc_in, prod_ff, prod_in;
   logic [63:0]  dividend_ff, dividend_in;
   logic [63:0]  result_ff, result_in;
   logic [5:0]   cnt_ff, cnt_in;
   logic         neg_q_ff, neg_q_in, neg_r_ff, neg_r_in, bzero_ff, bzero_in;

   logic [63:0]  wa, wb, val;
   logic [64:0]  shifted, diff;
   logic [31:0]  mul_x, mul_y;
   logic         na, nb;

   always_comb begin
      wa = op.word ? (op.sgn ? sx32(src_a) : {32'd0, src_a[31:0]}) : src_a;
      wb = op.word ? (op.sgn ? sx32(src_b) : {32'd0, src_b[31:0]}) : src_b;
      na = op.sgn & wa[63];
      nb = op.sgn & wb[63];
      shifted = {rem_ff, quo_ff[63]};
      diff = shifted - {1'b0, opb_ff};
      case (cnt_ff[1:0])
         2'd0:    begin mul_x = opa_ff[31:0];  mul_y = opb_ff[31:0];  end
         2'd1:    begin mul_x = opa_ff[31:0];  mul_y = opb_ff[63:32]; end
         default: begin mul_x = opa_ff[63:32]; mul_y = opb_ff[31:0];  end
      endcase
      prod_in = mul_x * mul_y;
   end

   always_comb begin
      state_in = state_ff;
      op_in = op_ff;
      opa_in = opa_ff;
      opb_in = opb_ff;
      rem_in = rem_ff;
      quo_in = quo_ff;
      acc_in = acc_ff;
      dividend_in = dividend_ff;
      result_in = result_ff;
      cnt_in = cnt_ff;
      neg_q_in = neg_q_ff;
      neg_r_in = neg_r_ff;
      bzero_in = bzero_ff;
      val = '0;
      unique case (state_ff)
         MD_IDLE, MD_DONE: begin
            if (start) begin
               op_in = op;
               cnt_in = '0;
               acc_in = '0;
               rem_in = '0;
               neg_q_in = na ^ nb;
               neg_r_in = na;
               bzero_in = (wb == 64'd0);
               dividend_in = wa;
               if (op.is_mul) begin
                  opa_in = src_a;
                  opb_in = src_b;
                  state_in = MD_MUL;
               end else begin
                  quo_in = na ? 64'd0 - wa : wa;
                  opb_in = nb ? 64'd0 - wb : wb;
                  state_in = MD_DIV;
               end
            end
         end
         MD_MUL: begin
            // The product registered last cycle is added in here.
            if (cnt_ff[1:0] == 2'd1) begin
               acc_in = prod_ff;
            end else if (cnt_ff[1:0] != 2'd0) begin
               acc_in = acc_ff + {prod_ff[31:0], 32'd0};
            end
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff[1:0] == 2'd3) begin
               state_in = MD_FIX;
            end
         end
         MD_DIV: begin
            if (!diff[64]) begin
               rem_in = diff[63:0];
               quo_in = {quo_ff[62:0], 1'b1};
            end else begin
               rem_in = shifted[63:0];
               quo_in = {quo_ff[62:0], 1'b0};
            end
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'd63) begin
               state_in = MD_FIX;
            end
         end
         MD_FIX: begin
            if (op_ff.is_mul) begin
               val = acc_ff;
            end else if (bzero_ff) begin
               val = op_ff.rem ? dividend_ff : '1;
            end else if (op_ff.rem) begin
               val = neg_r_ff ? 64'd0 - rem_ff : rem_ff;
            end else begin
               val = neg_q_ff ? 64'd0 - quo_ff : quo_ff;
            end
            result_in = op_ff.word ? sx32(val) : val;
            state_in = MD_DONE;
         end
         default: state_in = MD_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= MD_IDLE;
      end else begin
         state_ff <= state_in;
      end
      op_ff <= op_in;
      opa_ff <= opa_in;
      opb_ff <= opb_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      acc_ff <= acc_in;
      prod_ff <= prod_in;
      dividend_ff <= dividend_in;
      result_ff <= result_in;
      cnt_ff <= cnt_in;
      neg_q_ff <= neg_q_in;
      neg_r_ff <= neg_r_in;
      bzero_ff <= bzero_in;
   end

   assign done = (state_ff == MD_DONE);
   assign result = result_ff;

endmodule

// ===== hw/rtl/rvx_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rvx_datapath
// Program counter, input word register, combinational ALU, branch and memory
// decode, the multiply/divide unit and the result register.
// ----------------------------------------------------------------------------
module rvx_datapath (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_write_enable,
   input  logic [63:0]        csr_write_data,
   input  rvx_pkg::cmd_type   cmd,
   output rvx_pkg::status_type status,
   input  logic [5:0]         in_kind,
   input  logic [167:0]       in_data,
   output logic [271:0]       out_data
);
   import rvx_pkg::*;

   logic [63:0] pc_ff, pc_in;
   kind_type    kind_ff;
   logic [63:0] a_ff, b_ff, imm_ff, cur_pc_ff, next_pc_ff;
   logic [4:0]  rd_ff;
   logic [271:0] out_ff;

   logic [63:0] val, target, addr, sdata, md_result, pc_step;
   logic        wr, redir, sgnld, cond;
   logic [1:0]  mop, msize, trap;
   logic [5:0]  sh6, rs6;
   logic [4:0]  sh5, rs5;
   logic        md_done;
   md_op_type   md_op;

   assign pc_step = in_data[165] ? 64'd2 : 64'd4;

   always_comb begin
      pc_in = pc_ff;
      if (csr_write_enable) begin
         pc_in = csr_write_data;
      end else if (cmd.accept) begin
         pc_in = pc_ff + pc_step;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= '0;
      end else begin
         pc_ff <= pc_in;
      end
      if (cmd.accept) begin
         kind_ff <= in_kind;
         a_ff <= in_data[63:0];
         b_ff <= in_data[127:64];
         imm_ff <= {{32{in_data[159]}}, in_data[159:128]};
         rd_ff <= in_data[164:160];
         cur_pc_ff <= pc_ff;
         next_pc_ff <= pc_ff + pc_step;
      end
      if (cmd.load_alu || cmd.load_md) begin
         out_ff <= {2'd0, trap, sdata, addr, sgnld, msize, mop, target, redir, rd_ff,
                    wr && (rd_ff != 5'd0),
                    (wr && (rd_ff != 5'd0)) ? (cmd.load_md ? md_result : val) : 64'd0};
      end
   end

   always_comb begin
      sh6 = imm_ff[5:0];
      sh5 = imm_ff[4:0];
      rs6 = b_ff[5:0];
      rs5 = b_ff[4:0];
      val = '0;
      target = '0;
      addr = '0;
      sdata = '0;
      wr = 1'b0;
      redir = 1'b0;
      sgnld = 1'b0;
      mop = MEM_NONE;
      msize = 2'd0;
      trap = TRAP_NONE;
      cond = 1'b0;
      unique case (kind_ff)
         K_BEQ:   cond = (a_ff == b_ff);
         K_BNE:   cond = (a_ff != b_ff);
         K_BLT:   cond = ($signed(a_ff) < $signed(b_ff));
         K_BGE:   cond = !($signed(a_ff) < $signed(b_ff));
         K_BLTU:  cond = (a_ff < b_ff);
         K_BGEU:  cond = (a_ff >= b_ff);
         default: cond = 1'b0;
      endcase
      unique case (kind_ff)
         K_LUI:   begin val = imm_ff; wr = 1'b1; end
         K_AUIPC: begin val = cur_pc_ff + imm_ff; wr = 1'b1; end
         K_JAL: begin
            val = next_pc_ff; wr = 1'b1; redir = 1'b1; target = cur_pc_ff + imm_ff;
         end
         K_JALR: begin
            val = next_pc_ff; wr = 1'b1; redir = 1'b1;
            target = (a_ff + imm_ff) & ~64'd1;
         end
         K_BEQ, K_BNE, K_BLT, K_BGE, K_BLTU, K_BGEU: begin
            redir = cond; target = cur_pc_ff + imm_ff;
         end
         K_ADDI:  begin val = a_ff + imm_ff; wr = 1'b1; end
         K_XORI:  begin val = a_ff ^ imm_ff; wr = 1'b1; end
         K_ORI:   begin val = a_ff | imm_ff; wr = 1'b1; end
         K_ANDI:  begin val = a_ff & imm_ff; wr = 1'b1; end
         K_SLLI:  begin val = a_ff << sh6; wr = 1'b1; end
         K_SRLI:  begin val = a_ff >> sh6; wr = 1'b1; end
         K_SRAI:  begin val = $unsigned($signed(a_ff) >>> sh6); wr = 1'b1; end
         K_SLTI: begin
            val = {63'd0, $signed(a_ff) < $signed(imm_ff)}; wr = 1'b1;
         end
         K_SLTIU: begin val = {63'd0, a_ff < imm_ff}; wr = 1'b1; end
         K_ADDIW: begin val = sx32(a_ff + imm_ff); wr = 1'b1; end
         K_SLLIW: begin val = sx32(a_ff << sh5); wr = 1'b1; end
         K_SRLIW: begin val = sx32({32'd0, a_ff[31:0]} >> sh5); wr = 1'b1; end
         K_SRAIW: begin val = sx32($unsigned($signed(sx32(a_ff)) >>> sh5)); wr = 1'b1; end
         K_ADD:   begin val = a_ff + b_ff; wr = 1'b1; end
         K_SUB:   begin val = a_ff - b_ff; wr = 1'b1; end
         K_XOR:   begin val = a_ff ^ b_ff; wr = 1'b1; end
         K_OR:    begin val = a_ff | b_ff; wr = 1'b1; end
         K_AND:   begin val = a_ff & b_ff; wr = 1'b1; end
         K_SLT: begin
            val = {63'd0, $signed(a_ff) < $signed(b_ff)}; wr = 1'b1;
         end
         K_SLTU:  begin val = {63'd0, a_ff < b_ff}; wr = 1'b1; end
         K_SLL:   begin val = a_ff << rs6; wr = 1'b1; end
         K_SRL:   begin val = a_ff >> rs6; wr = 1'b1; end
         K_SRA:   begin val = $unsigned($signed(a_ff) >>> rs6); wr = 1'b1; end
         K_ADDW:  begin val = sx32(a_ff + b_ff); wr = 1'b1; end
         K_SUBW:  begin val = sx32(a_ff - b_ff); wr = 1'b1; end
         K_SLLW:  begin val = sx32(a_ff << rs5); wr = 1'b1; end
         K_SRLW:  begin val = sx32({32'd0, a_ff[31:0]} >> rs5); wr = 1'b1; end
         K_SRAW:  begin val = sx32($unsigned($signed(sx32(a_ff)) >>> rs5)); wr = 1'b1; end
         K_LB, K_LH, K_LW: begin
            mop = MEM_LOAD; addr = a_ff + imm_ff; sgnld = 1'b1;
            msize = 2'(kind_ff - K_LB);
         end
         K_LBU, K_LHU, K_LWU: begin
            mop = MEM_LOAD; addr = a_ff + imm_ff; msize = 2'(kind_ff - K_LBU);
         end
         K_LD: begin mop = MEM_LOAD; addr = a_ff + imm_ff; msize = 2'd3; end
         K_SB, K_SH, K_SW, K_SD: begin
            mop = MEM_STORE; addr = a_ff + imm_ff; sdata = b_ff;
            msize = 2'(kind_ff - K_SB);
         end
         K_ECALL:  trap = TRAP_ECALL;
         K_EBREAK: trap = TRAP_EBREAK;
         K_MUL, K_MULW, K_DIV, K_DIVW, K_DIVU, K_DIVUW,
         K_REM, K_REMW, K_REMU, K_REMUW: wr = 1'b1;
         default: trap = TRAP_UNSUP;
      endcase
   end

   always_comb begin
      md_op.is_mul = (kind_ff == K_MUL) || (kind_ff == K_MULW);
      md_op.word = (kind_ff == K_MULW) || (kind_ff == K_DIVW) || (kind_ff == K_DIVUW) ||
                   (kind_ff == K_REMW) || (kind_ff == K_REMUW);
      md_op.sgn = (kind_ff == K_DIV) || (kind_ff == K_DIVW) || (kind_ff == K_REM) ||
                  (kind_ff == K_REMW);
      md_op.rem = (kind_ff == K_REM) || (kind_ff == K_REMW) || (kind_ff == K_REMU) ||
                  (kind_ff == K_REMUW);
   end

   rvx_muldiv u_muldiv (
      .clock  (clock),
      .reset  (reset),
      .start  (cmd.start_md),
      .op     (md_op),
      .src_a  (a_ff),
      .src_b  (b_ff),
      .done   (md_done),
      .result (md_result)
   );

   assign status.is_md = (kind_ff >= K_MUL) && (kind_ff <= K_REMUW);
   assign status.md_done = md_done;
   assign out_data = out_ff;

endmodule

// ===== hw/rtl/rvx_controller.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rvx_controller
// Sequences one word at a time: capture, execute or wait for the
// multiply/divide unit, then hand the result to the output register.
// ----------------------------------------------------------------------------
module rvx_controller (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   input  rvx_pkg::status_type status,
   output rvx_pkg::cmd_type    cmd
);
   import rvx_pkg::*;

   ctl_state_type state_ff, state_in;
   logic          valid_ff, valid_in;
   logic          slot_free;

   assign slot_free = !valid_ff || rsp_tready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         CTL_IDLE: if (req_tvalid) state_in = CTL_ALU;
         CTL_ALU: begin
            if (status.is_md) begin
               state_in = CTL_MD;
            end else if (slot_free) begin
               state_in = CTL_IDLE;
            end
         end
         CTL_MD: if (status.md_done && slot_free) state_in = CTL_IDLE;
         default: state_in = CTL_IDLE;
      endcase
   end

   always_comb begin
      req_tready = (state_ff == CTL_IDLE);
      cmd.accept = (state_ff == CTL_IDLE) && req_tvalid;
      cmd.start_md = (state_ff == CTL_ALU) && status.is_md;
      cmd.load_alu = (state_ff == CTL_ALU) && !status.is_md && slot_free;
      cmd.load_md = (state_ff == CTL_MD) && status.md_done && slot_free;
      if (cmd.load_alu || cmd.load_md) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CTL_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   assign rsp_tvalid = valid_ff;

endmodule

// ===== hw/rtl/rv64im_integer_execute_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rv64im_integer_execute_core
// RV64IM execute unit: one decoded instruction word in, one result word out.
// ----------------------------------------------------------------------------
// Words are executed one at a time. An ALU, branch, jump, memory or trap word
// is held in the input word register and its result is then registered in the
// output register. MUL and MULW pass four times through one 32x32 multiplier.
// Divide and remainder forms use the one-bit-per-cycle restoring divider.
// The next word is accepted as soon as the result is in the output register,
// even while that result still waits to be taken. A write on the csr port
// loads the pc of the next instruction; it must come while the core is idle.
module rv64im_integer_execute_core (
   input  logic           clock,
   input  logic           reset,
   input  logic           csr_write_enable,
   input  logic [63:0]    csr_write_data,
   input  logic           req_tvalid,
   output logic           req_tready,
   // tuser: kind[5:0]
   input  logic [5:0]     req_tuser,
   // tdata: src1_value[63:0], src2_value[127:64], immediate[159:128],
   //        dest_reg[164:160], compressed[165], zero pad[167:166]
   input  logic [167:0]   req_tdata,
   output logic           rsp_tvalid,
   input  logic           rsp_tready,
   // tdata: result_value[63:0], write_enable[64], write_reg[69:65],
   //        redirect[70], target_address[134:71], mem_op[136:135],
   //        mem_size[138:137], mem_signed[139], mem_address[203:140],
   //        store_data[267:204], trap[269:268], zero pad[271:270]
   output logic [271:0]   rsp_tdata
);
   import rvx_pkg::*;

   cmd_type    cmd;
   status_type status;

   rvx_controller u_ctl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   rvx_datapath u_dp (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .cmd              (cmd),
      .status           (status),
      .in_kind          (req_tuser),
      .in_data          (req_tdata),
      .out_data         (rsp_tdata)
   );

endmodule

// ===== hw/rtl/rvx_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rvx_checker
// Port-level checks of the execute core, bound to the top level.
// ----------------------------------------------------------------------------
module rvx_checker (
   input logic         clock,
   input logic         reset,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [271:0] rsp_tdata
);
   import rvx_pkg::*;

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result word dropped or changed while stalled");

   a_x0: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[64] |-> rsp_tdata[69:65] != 5'd0)
      else $error("write reported for x0");

   a_nomem: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[136:135] == MEM_NONE |->
         rsp_tdata[203:140] == 64'd0 && rsp_tdata[267:204] == 64'd0)
      else $error("memory fields set without memory access");

   a_trap: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[269:268] != TRAP_NONE |->
         !rsp_tdata[64] && !rsp_tdata[70])
      else $error("trap word writes or redirects");

endmodule

bind rv64im_integer_execute_core rvx_checker u_rvx_checker (.*);
